// ----- rtl/core/utf8t_pkg.sv -----
package utf8t_pkg;

    // character queue between the front and back parts
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // wrapper tag lengths: "<oov>" and "</oov>"
    localparam logic [3:0] OPEN_TAG_LEN  = 4'd5;
    localparam logic [3:0] CLOSE_TAG_LEN = 4'd6;
    localparam logic [3:0] TAG_TOTAL_LEN = OPEN_TAG_LEN + CLOSE_TAG_LEN;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_V     = 8'h76;

    localparam logic [20:0] ASCII_LO    = 21'h00020;
    localparam logic [20:0] ASCII_HI    = 21'h0007E;
    localparam logic [20:0] CJK_LO      = 21'h04E00;
    localparam logic [20:0] CJK_HI      = 21'h09FFF;
    localparam logic [20:0] CJK_EXT_LO  = 21'h03400;
    localparam logic [20:0] CJK_EXT_HI  = 21'h04DBF;
    localparam logic [20:0] CJK_COMP_LO = 21'h0F900;
    localparam logic [20:0] CJK_COMP_HI = 21'h0FAFF;
    localparam logic [20:0] CJK_PUNC_LO = 21'h03000;
    localparam logic [20:0] CJK_PUNC_HI = 21'h0303F;
    localparam logic [20:0] GEN_PUNC_LO = 21'h02000;
    localparam logic [20:0] GEN_PUNC_HI = 21'h0206F;
    localparam logic [20:0] FULLW_LO    = 21'h0FF00;
    localparam logic [20:0] FULLW_HI    = 21'h0FFEF;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      len;
        logic            known;
    } t_char_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [1:0] held;
        logic [2:0] len;
    } t_front_status;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        if (b[7:3] == 5'b11110) begin
            return 3'd4;
        end else if (b[7:4] == 4'b1110) begin
            return 3'd3;
        end else if (b[7:5] == 3'b110) begin
            return 3'd2;
        end
        return 3'd1;
    endfunction

    function automatic logic [20:0] decode(input logic [3:0][7:0] c, input logic [2:0] len);
        logic [20:0] cp;
        case (len)
            3'd2: cp = {10'd0, c[0][4:0], c[1][5:0]};
            3'd3: cp = {5'd0, c[0][3:0], c[1][5:0], c[2][5:0]};
            3'd4: cp = {c[0][2:0], c[1][5:0], c[2][5:0], c[3][5:0]};
            default: cp = {13'd0, c[0]};
        endcase
        return cp;
    endfunction

    function automatic logic known_point(input logic [20:0] cp);
        return (cp >= ASCII_LO    && cp <= ASCII_HI)    ||
               (cp >= CJK_LO      && cp <= CJK_HI)      ||
               (cp >= CJK_EXT_LO  && cp <= CJK_EXT_HI)  ||
               (cp >= CJK_COMP_LO && cp <= CJK_COMP_HI) ||
               (cp >= CJK_PUNC_LO && cp <= CJK_PUNC_HI) ||
               (cp >= GEN_PUNC_LO && cp <= GEN_PUNC_HI) ||
               (cp >= FULLW_LO    && cp <= FULLW_HI);
    endfunction

    function automatic logic [7:0] open_tag_byte(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0: ch = CH_LT;
            4'd1: ch = CH_O;
            4'd2: ch = CH_O;
            4'd3: ch = CH_V;
            default: ch = CH_GT;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] close_tag_byte(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0: ch = CH_LT;
            4'd1: ch = CH_SLASH;
            4'd2: ch = CH_O;
            4'd3: ch = CH_O;
            4'd4: ch = CH_V;
            default: ch = CH_GT;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/utf8t_front.sv -----
module utf8t_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_in_byte,
    input  utf8t_pkg::t_queue_status i_queue,
    output logic                     o_push,
    output utf8t_pkg::t_char_rec     o_rec,
    output utf8t_pkg::t_front_status o_status
);

    logic [1:0]      r_held, n_held;
    logic [2:0]      r_len, n_len;
    logic [7:0]      r_pend [3];
    logic            accept;
    logic            done;
    logic [2:0]      lead;
    logic [2:0]      eff_len;
    logic [3:0][7:0] chars;

    assign o_stall = i_queue.full;
    assign accept  = i_valid && !i_queue.full;
    assign lead    = utf8t_pkg::lead_length(i_in_byte);
    assign eff_len = (r_held == 2'd0) ? lead : r_len;

    // the incoming byte lands at the slot given by the held count
    assign chars[0] = (r_held == 2'd0) ? i_in_byte : r_pend[0];
    assign chars[1] = (r_held == 2'd1) ? i_in_byte : r_pend[1];
    assign chars[2] = (r_held == 2'd2) ? i_in_byte : r_pend[2];
    assign chars[3] = i_in_byte;

    assign done = (r_held == 2'd0) ? (lead == 3'd1) : (({1'b0, r_held} + 3'd1) == r_len);

    assign o_push      = accept && done;
    assign o_rec.data  = chars;
    assign o_rec.len   = eff_len;
    assign o_rec.known = utf8t_pkg::known_point(utf8t_pkg::decode(chars, eff_len));

    assign o_status.held = r_held;
    assign o_status.len  = r_len;

    always_comb begin
        n_held = r_held;
        n_len  = r_len;
        if (accept) begin
            if (done) begin
                n_held = 2'd0;
                n_len  = 3'd0;
            end else if (r_held == 2'd0) begin
                n_held = 2'd1;
                n_len  = lead;
            end else begin
                n_held = r_held + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 2'd0;
            r_len  <= 3'd0;
        end else begin
            r_held <= n_held;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !done) begin
            r_pend[r_held] <= i_in_byte;
        end
    end

endmodule

// ----- rtl/core/utf8t_queue.sv -----
module utf8t_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  utf8t_pkg::t_char_rec     i_rec,
    input  logic                     i_pop,
    output utf8t_pkg::t_char_rec     o_head,
    output utf8t_pkg::t_queue_status o_status
);

    localparam int unsigned PTR_W = utf8t_pkg::QUEUE_PTR_W;
    localparam int unsigned CNT_W = utf8t_pkg::QUEUE_CNT_W;

    utf8t_pkg::t_char_rec r_mem [utf8t_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr, n_wr;
    logic [PTR_W-1:0]     r_rd, n_rd;
    logic [CNT_W-1:0]     r_count, n_count;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(utf8t_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(utf8t_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(utf8t_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

// ----- rtl/core/utf8t_back.sv -----
module utf8t_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  utf8t_pkg::t_char_rec     i_head,
    input  utf8t_pkg::t_queue_status i_queue,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [7:0]               o_out_byte,
    output logic                     o_run_last
);

    logic [3:0] r_pos, n_pos;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       last;
    logic [3:0] total;
    logic [3:0] body_off;
    logic [3:0] close_off;
    logic [7:0] sel_byte;

    assign total = i_head.known ? {1'b0, i_head.len}
                                : {1'b0, i_head.len} + utf8t_pkg::TAG_TOTAL_LEN;
    assign last  = (r_pos == total - 4'd1);
    assign load  = !i_queue.empty && (!r_valid || !i_stall);
    assign o_pop = load && last;

    assign body_off  = r_pos - utf8t_pkg::OPEN_TAG_LEN;
    assign close_off = body_off - {1'b0, i_head.len};

    always_comb begin
        if (i_head.known) begin
            sel_byte = i_head.data[r_pos[1:0]];
        end else if (r_pos < utf8t_pkg::OPEN_TAG_LEN) begin
            sel_byte = utf8t_pkg::open_tag_byte(r_pos);
        end else if (body_off < {1'b0, i_head.len}) begin
            sel_byte = i_head.data[body_off[1:0]];
        end else begin
            sel_byte = utf8t_pkg::close_tag_byte(close_off);
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_pos   = last ? 4'd0 : r_pos + 4'd1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_run_last = r_last;

endmodule

// ----- rtl/core/utf8_unknown_char_tagger_unit.sv -----
// utf8 unknown-character tagger
// input channel: one raw utf-8 byte per request on i_in_byte, taken at a clock edge
// with i_valid high and o_stall low. output channel: one byte per request on
// o_out_byte, taken at an edge with o_valid high and i_stall low; o_run_last marks
// the final output byte belonging to one character.
// a character whose code point lies in a known range is passed on unchanged; any
// other character is sent as <oov>, its raw bytes, then </oov>.
// a character enters the queue with its final input byte and leaves it byte by byte
// through the output register; bytes that do not complete a character give no output.
// throughput: one input byte per cycle while o_stall is low, one output byte per cycle
// while i_stall is low. a known character of n bytes gives n output bytes, an unknown
// one n + 11; the output byte rate sets the pace, and a two-entry character queue
// between the decoder and output serialiser absorbs short bursts before o_stall rises.
// while i_stall is high the output register holds its byte, the serialiser waits,
// and once the queue fills o_stall is raised towards the sender.
// reset (i_rst_n low, synchronous) empties the queue, drops any part-collected
// character and clears o_valid; the block takes input once reset is released.
module utf8_unknown_char_tagger_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    utf8t_pkg::t_char_rec     push_rec;
    utf8t_pkg::t_char_rec     head_rec;
    utf8t_pkg::t_queue_status queue_status;
    utf8t_pkg::t_front_status front_status;
    logic                     push;
    logic                     pop;

    utf8t_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_byte (i_in_byte),
        .i_queue   (queue_status),
        .o_push    (push),
        .o_rec     (push_rec),
        .o_status  (front_status)
    );

    utf8t_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_head   (head_rec),
        .o_status (queue_status)
    );

    utf8t_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_rec),
        .i_queue    (queue_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !queue_status.full)
        else $error("character queue written while full");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !queue_status.empty)
        else $error("character queue popped while empty");

    // a part-collected character always has fewer bytes than its length
    a_held_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_status.held != 2'd0) |->
            (({1'b0, front_status.held} < front_status.len) && (front_status.len >= 3'd2)))
        else $error("collected byte count out of step with character length");

    // a character's output run is not broken by a gap
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_run_last) |=> o_valid)
        else $error("gap inside a character's output run");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RAND_ITEMS   = 257;
    localparam int unsigned SETTLE_TICKS = 20;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [39:0] OPEN_TAG     = "<oov>";
    localparam logic [47:0] CLOSE_TAG    = "</oov>";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    t_text_byte  expected_text_q[$];
    logic [7:0]  held_bytes[3];
    logic [1:0]  held_cnt;
    logic [2:0]  cur_len;
    int unsigned mismatch_cnt;
    int unsigned cycle_cnt;
    int unsigned sent_cnt;
    int unsigned burst_left;

    utf8_unknown_char_tagger_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        casez (b)
            8'b110?????: lead_len = 3'd2;
            8'b1110????: lead_len = 3'd3;
            8'b11110???: lead_len = 3'd4;
            default:     lead_len = 3'd1;
        endcase
    endfunction

    function automatic logic [20:0] char_point(input logic [3:0][7:0] chars,
                                               input logic [2:0] n);
        case (n)
            3'd2:    char_point = {10'd0, chars[0][4:0], chars[1][5:0]};
            3'd3:    char_point = {5'd0, chars[0][3:0], chars[1][5:0], chars[2][5:0]};
            3'd4:    char_point = {chars[0][2:0], chars[1][5:0], chars[2][5:0],
                                   chars[3][5:0]};
            default: char_point = {13'd0, chars[0]};
        endcase
    endfunction

    function automatic bit in_known_range(input logic [20:0] cp);
        return (cp >= 21'h00020 && cp <= 21'h0007E) ||
               (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
               (cp >= 21'h03400 && cp <= 21'h04DBF) ||
               (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
               (cp >= 21'h03000 && cp <= 21'h0303F) ||
               (cp >= 21'h02000 && cp <= 21'h0206F) ||
               (cp >= 21'h0FF00 && cp <= 21'h0FFEF);
    endfunction

    task automatic queue_char_text(input logic [3:0][7:0] chars, input logic [2:0] n);
        bit          known;
        int unsigned total;
        int unsigned idx;
        t_text_byte  rec;
        known = in_known_range(char_point(chars, n));
        total = known ? n : n + 11;
        idx   = 0;
        for (int k = 0; k < 16; k++) begin
            if (idx < total) begin
                if (known) begin
                    rec.ch = chars[k];
                end else if (k < 5) begin
                    rec.ch = OPEN_TAG[39 - 8 * k -: 8];
                end else if (k < 5 + n) begin
                    rec.ch = chars[k - 5];
                end else begin
                    rec.ch = CLOSE_TAG[47 - 8 * (k - 5 - n) -: 8];
                end
                rec.last = (idx == total - 1);
                expected_text_q.push_back(rec);
                idx++;
            end
        end
    endtask

    task automatic tag_char_predict(input logic [7:0] b);
        logic [3:0][7:0] chars;
        logic [2:0]      n;
        chars = '0;
        if (held_cnt == 2'd0) begin
            n = lead_len(b);
            if (n == 3'd1) begin
                chars[0] = b;
                queue_char_text(chars, n);
            end else begin
                held_bytes[0] = b;
                held_cnt      = 2'd1;
                cur_len       = n;
            end
        end else if (held_cnt + 1 < cur_len) begin
            held_bytes[held_cnt] = b;
            held_cnt             = held_cnt + 2'd1;
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (k < held_cnt) chars[k] = held_bytes[k];
            end
            chars[held_cnt] = b;
            n        = cur_len;
            held_cnt = 2'd0;
            cur_len  = 3'd0;
            queue_char_text(chars, n);
        end
    endtask

    // ---------------------------------------------------------------- sender side

    task automatic sender_pause();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                i_valid   = 1'b0;
                i_in_byte = 8'($urandom_range(0, 255));
                @(negedge i_clk);
            end
        end
    endtask

    // called at a falling edge; valid stays high for the next request unless the pause after it drops valid
    task automatic send_byte(input logic [7:0] b);
        i_valid   = 1'b1;
        i_in_byte = b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tag_char_predict(b);
        sent_cnt++;
        @(negedge i_clk);
        sender_pause();
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (expected_text_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic send_char(input logic [20:0] cp, input bit overlong, input bit rough_cont);
        logic [2:0]      n;
        logic [3:0][7:0] enc;
        enc = '0;
        if (cp < 21'h80) n = 3'd1;
        else if (cp < 21'h800) n = 3'd2;
        else if (cp < 21'h10000) n = 3'd3;
        else n = 3'd4;
        if (overlong && n < 3'd4) n = n + 3'd1;
        case (n)
            3'd1: enc[0] = {1'b0, cp[6:0]};
            3'd2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3'd3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        // continuation bytes with arbitrary top bits still decode from the low six
        if (rough_cont) begin
            for (int k = 1; k < 4; k++) begin
                if (k < n) enc[k][7:6] = 2'($urandom_range(0, 3));
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (k < n) send_byte(enc[k]);
        end
    endtask

    function automatic logic [20:0] pick_point();
        int unsigned sel;
        int unsigned r;
        logic [20:0] lo;
        logic [20:0] hi;
        sel = $urandom_range(0, 9);
        r   = $urandom_range(0, 6);
        case (r)
            0:       begin lo = 21'h00020; hi = 21'h0007E; end
            1:       begin lo = 21'h04E00; hi = 21'h09FFF; end
            2:       begin lo = 21'h03400; hi = 21'h04DBF; end
            3:       begin lo = 21'h0F900; hi = 21'h0FAFF; end
            4:       begin lo = 21'h03000; hi = 21'h0303F; end
            5:       begin lo = 21'h02000; hi = 21'h0206F; end
            default: begin lo = 21'h0FF00; hi = 21'h0FFEF; end
        endcase
        // often just around a range boundary; otherwise inside the range or at random
        case (sel)
            0, 1:    pick_point = 21'(lo + $urandom_range(0, 2) - 1);
            2, 3:    pick_point = 21'(hi + $urandom_range(0, 2) - 1);
            4, 5:    pick_point = 21'(lo + $urandom_range(0, hi - lo));
            6:       pick_point = 21'($urandom_range(0, 8'h7F));
            7:       pick_point = 21'($urandom_range(0, 16'hFFFF));
            default: pick_point = 21'($urandom & 32'h001F_FFFF);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_single_byte_limits();
        send_byte(8'h00);
        send_byte(8'h20);
        send_byte(8'h7E);
        send_byte(8'h7F);
    endtask

    task automatic test_invalid_leads();
        send_byte(8'h80);
        send_byte(8'hF8);
        send_byte(8'hFF);
    endtask

    task automatic test_known_multibyte();
        send_byte(8'hE4);
        send_byte(8'hB8);
        send_byte(8'h80);
        send_byte(8'hEF);
        send_byte(8'hBC);
        send_byte(8'h81);
    endtask

    task automatic test_unknown_multibyte();
        send_byte(8'hC2);
        send_byte(8'hA9);
        send_byte(8'hF0);
        send_byte(8'h9F);
        send_byte(8'h98);
        send_byte(8'h80);
    endtask

    task automatic test_overlong_codes();
        send_byte(8'hC0);
        send_byte(8'hA0);
        send_byte(8'hC1);
        send_byte(8'hBF);
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hE4);
        send_byte(8'h38);
        send_byte(8'h00);
    endtask

    // character left incomplete while the output drains, then finished
    task automatic test_split_character();
        send_byte(8'hE5);
        wait_drained();
        send_byte(8'h91);
        send_byte(8'hA8);
    endtask

    // back-to-back long tagged runs fill the queue, then the sender holds off
    task automatic test_backlog_release();
        repeat (6) send_char(21'(21'h10000 + $urandom_range(0, 21'h0FFFF)), 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_stream();
        int unsigned start;
        start = sent_cnt;
        while (sent_cnt - start < RAND_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                send_char(pick_point(), $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) == 0) wait_drained();
        end
    endtask

    // ---------------------------------------------------------------- receiver side

    initial begin : stall_pattern
        int unsigned mode;
        int unsigned span;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_stall = 1'b0;
                    1:       i_stall = ($urandom_range(0, 3) == 0);
                    2:       i_stall = ($urandom_range(0, 3) != 0);
                    default: i_stall = ~i_stall;
                endcase
            end
        end
    end

    function automatic void note_mismatch(input string what, input t_text_byte want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, want.ch, want.last, o_out_byte, o_run_last);
        end
    endfunction

    always @(posedge i_clk) begin : check_output
        t_text_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_text_q.size() == 0) begin
                want = '0;
                note_mismatch("byte with nothing expected", want);
            end else begin
                want = expected_text_q.pop_front();
                if (o_out_byte !== want.ch || o_run_last !== want.last) begin
                    note_mismatch("output mismatch", want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in_byte  = 8'h00;
        held_cnt   = 2'd0;
        cur_len    = 3'd0;
        burst_left = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_byte_limits();
        test_invalid_leads();
        test_known_multibyte();
        test_unknown_multibyte();
        test_overlong_codes();
        test_bad_continuation();
        test_split_character();
        test_backlog_release();
        test_random_stream();

        wait_drained();
        if (mismatch_cnt == 0 && expected_text_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
